// ===== rtl/opi_pkg.sv =====
// Shared constants, types and helper functions of the odometry pose integrator.
package opi_pkg;

   // Refresh cycle length and CORDIC iteration count.
   localparam int REFRESH_PERIOD = 128;
   localparam int PC_W           = (REFRESH_PERIOD > 2) ? $clog2(REFRESH_PERIOD) : 1;
   localparam int CORDIC_STEPS   = 24;

   // Divider widths: dividend is magnitude << 24 plus half the divisor.
   localparam int DIV_W = 56;

   // Angle constants in Q3.29, CORDIC seed in Q2.30.
   localparam logic signed [33:0] PI_Q         = 34'sd1686629713;
   localparam logic signed [33:0] TWO_PI_Q     = 34'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q    = 34'sd843314856;
   localparam logic signed [35:0] CORDIC_START = 36'sd652032874;

   // Position limits in Q32.16 ticks.
   localparam logic signed [49:0] T48_MAX = 50'sd140737488355327;
   localparam logic signed [49:0] T48_MIN = -50'sd140737488355328;

   // Register reset values and indexes.
   localparam logic [31:0] MPT_RESET  = 32'd42950;
   localparam logic [6:0]  SLOT_RESET = 7'd64;
   localparam logic        CSR_MPT    = 1'b0;
   localparam logic        CSR_SLOT   = 1'b1;
   localparam logic [31:0] COS_RESET  = 32'h4000_0000;

   // Result of the CORDIC unit.
   typedef struct packed {
      logic               done;
      logic signed [31:0] cos;
      logic signed [31:0] sin;
   } cordic_res_type;

   // Result of the divider unit.
   typedef struct packed {
      logic               done;
      logic signed [47:0] ticks;
   } div_res_type;

   // Arctangent table, Q2.30.
   function automatic logic signed [33:0] atan_val(input logic [4:0] idx);
      logic signed [33:0] r;
      case (idx)
         5'd0:    r = 34'sd843314857;
         5'd1:    r = 34'sd497837829;
         5'd2:    r = 34'sd263043837;
         5'd3:    r = 34'sd133525159;
         5'd4:    r = 34'sd67021687;
         5'd5:    r = 34'sd33543516;
         5'd6:    r = 34'sd16775851;
         5'd7:    r = 34'sd8388437;
         5'd8:    r = 34'sd4194283;
         5'd9:    r = 34'sd2097149;
         5'd31:   r = 34'sd0;
         default: r = 34'sd1 <<< (5'd30 - idx);
      endcase
      return r;
   endfunction

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // One step of 2*pi brings the angle into (-pi, pi].
   function automatic logic signed [31:0] wrap_angle(input logic signed [33:0] a);
      logic signed [33:0] r;
      if (a > PI_Q) begin
         r = a - TWO_PI_Q;
      end else if (a <= -PI_Q) begin
         r = a + TWO_PI_Q;
      end else begin
         r = a;
      end
      return r[31:0];
   endfunction

endpackage

// ===== rtl/opi_mul.sv =====
// Shared signed multiplier with a registered product.
module opi_mul (
   input  logic               clock,
   input  logic signed [32:0] a,
   input  logic signed [32:0] b,
   output logic signed [65:0] p
);

   logic signed [65:0] p_ff;
   logic signed [65:0] p_in;

   // One product per cycle, available the cycle after the operands.
   assign p_in = a * b;
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

// ===== rtl/opi_cordic.sv =====
// Iterative CORDIC in rotation mode giving cosine and sine of a heading.
module opi_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      heading,
   output opi_pkg::cordic_res_type res
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [35:0] x_ff, x_in;
   logic signed [35:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic signed [33:0] h_ext;
   logic signed [33:0] h_red;
   logic signed [35:0] dx;
   logic signed [35:0] dy;
   logic signed [35:0] xo;
   logic signed [35:0] yo;

   assign h_ext = {{2{heading[31]}}, heading};
   assign dx    = y_ff >>> cnt_ff[4:0];
   assign dy    = x_ff >>> cnt_ff[4:0];

   // Start reduces the heading into [-pi/2, pi/2]; each busy cycle is one rotation.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      h_red   = h_ext;
      if (start) begin
         neg_in = 1'b0;
         if (h_ext > opi_pkg::HALF_PI_Q) begin
            h_red  = h_ext - opi_pkg::PI_Q;
            neg_in = 1'b1;
         end else if (h_ext < -opi_pkg::HALF_PI_Q) begin
            h_red  = h_ext + opi_pkg::PI_Q;
            neg_in = 1'b1;
         end
         z_in    = h_red <<< 1;
         x_in    = opi_pkg::CORDIC_START;
         y_in    = 36'sd0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - opi_pkg::atan_val(cnt_ff[4:0]);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + opi_pkg::atan_val(cnt_ff[4:0]);
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(opi_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Undo the half-turn reduction and saturate.
   assign xo       = neg_ff ? -x_ff : x_ff;
   assign yo       = neg_ff ? -y_ff : y_ff;
   assign res.done = done_ff;
   assign res.cos  = opi_pkg::sat32({{4{xo[35]}}, xo});
   assign res.sin  = opi_pkg::sat32({{4{yo[35]}}, yo});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

endmodule

// ===== rtl/opi_div.sv =====
// Restoring divider turning meters into ticks, one quotient bit per cycle.
module opi_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [31:0]   meters,
   input  logic [31:0]          scale,
   output opi_pkg::div_res_type res
);

   localparam int DW = opi_pkg::DIV_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [DW-1:0]        n_ff, n_in;
   logic [DW-1:0]        q_ff, q_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          d_ff, d_in;
   logic [31:0]          d_sel;
   logic [31:0]          mag;
   logic [32:0]          trial;
   logic signed [49:0]   q_sat;

   assign d_sel = (scale == 32'd0) ? 32'd1 : scale;
   assign mag   = meters[31] ? (32'd0 - meters) : meters;
   assign trial = {rem_ff, n_ff[DW-1]};

   // Load the rounded dividend, then shift one bit through per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (start) begin
         neg_in  = meters[31];
         d_in    = d_sel;
         n_in    = {mag, 24'd0} + {25'd0, d_sel[31:1]};
         q_in    = '0;
         rem_in  = 32'd0;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = 32'(trial - {1'b0, d_ff});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         n_in   = {n_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Clamp to the 48-bit tick range and apply the sign.
   always_comb begin
      if ({1'b0, q_ff} > 57'(opi_pkg::T48_MAX)) begin
         q_sat = opi_pkg::T48_MAX;
      end else begin
         q_sat = 50'(q_ff);
      end
   end

   assign res.done  = done_ff;
   assign res.ticks = neg_ff ? 48'(-q_sat) : q_sat[47:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

endmodule

// ===== rtl/odometry_pose_integrator.sv =====
// Top level of the odometry pose integrator: sequencer, pose state and ports.
//
//   Channel  Direction  Ports       Contents (lowest bit first)
//   req      in         req_t*      tuser: kind; tdata: turn_step, distance_step,
//                                   set_x_m, set_y_m, set_heading
//   rsp      out        rsp_t*      tdata: x_m, y_m, heading_out
//   csr      in         csr_*       index 0 meters_per_tick, 1 sine_refresh_slot
//
// An integrate item runs the rotation and the position update and, when the period
// brings an exact cosine or sine, waits between them for the CORDIC (CORDIC_STEPS
// rotations and a done strobe). A set item runs the CORDIC and then the
// restoring divider, which yields one quotient bit per cycle, 56 bits for each axis.
// All products go through one 33x33 multiplier. Reset is synchronous and restores
// the reset pose. req_tready is high while idle unless a finished pose cannot move
// into the output register; a result waiting there lets the block take the next item.
module odometry_pose_integrator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,  // turn_step, distance_step, set_x_m, set_y_m, set_heading
   input  logic         req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // x_m, y_m, heading_out
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int PC_W = opi_pkg::PC_W;

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_DCOS  = 19'h00002,
      S_DSIN  = 19'h00004,
      S_ROT   = 19'h00008,
      S_SETH  = 19'h00010,
      S_CORD  = 19'h00020,
      S_MULX  = 19'h00040,
      S_MULY  = 19'h00080,
      S_ADDY  = 19'h00100,
      S_DXGO  = 19'h00200,
      S_DXW   = 19'h00400,
      S_DYGO  = 19'h00800,
      S_DYW   = 19'h01000,
      S_MXLO  = 19'h02000,
      S_MXHI  = 19'h04000,
      S_MXFIN = 19'h08000,
      S_MYLO  = 19'h10000,
      S_MYHI  = 19'h20000,
      S_MYFIN = 19'h40000
   } state_type;

   state_type          state_ff, state_in;
   logic               done_ff, done_in;
   logic signed [31:0] heading_ff, heading_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [47:0] xt_ff, xt_in;
   logic signed [47:0] yt_ff, yt_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [31:0]        mpt_ff, mpt_in;
   logic [6:0]         slot_ff, slot_in;
   logic signed [31:0] dt_ff, dt_in;
   logic signed [31:0] dv_ff, dv_in;
   logic signed [31:0] sx_ff, sx_in;
   logic signed [31:0] sy_ff, sy_in;
   logic               set_ff, set_in;
   logic signed [36:0] dcos_ff, dcos_in;
   logic               rc_ff, rc_in;
   logic               rs_ff, rs_in;
   logic [32:0]        plr_ff, plr_in;
   logic [31:0]        xm_ff, xm_in;
   logic [31:0]        ym_ff, ym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [95:0]        rsp_data_ff, rsp_data_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic signed [65:0] prod_r28;
   logic signed [65:0] prod_r29;
   logic signed [36:0] dterm;
   logic signed [35:0] inc;
   logic signed [33:0] head_sum;
   logic signed [31:0] head_wrap;
   logic signed [31:0] cord_head;
   logic               cord_start;
   logic               div_start;
   logic signed [31:0] div_meters;
   logic [47:0]        mag_x, mag_y;
   logic [57:0]        msum;
   logic               slot0, slot_hit;
   logic               out_free;
   opi_pkg::cordic_res_type cord_res;
   opi_pkg::div_res_type    div_res;

   // Saturate a 50-bit tick sum to 48 bits.
   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > opi_pkg::T48_MAX) begin
         r = opi_pkg::T48_MAX[47:0];
      end else if (v < opi_pkg::T48_MIN) begin
         r = opi_pkg::T48_MIN[47:0];
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   // Rounded meter magnitude to signed Q8.24 with saturation.
   function automatic logic [31:0] to_meters(input logic [57:0] r, input logic neg);
      logic [32:0] m;
      logic [31:0] o;
      if (r > 58'h8000_0000) begin
         m = 33'h0_8000_0000;
      end else begin
         m = r[32:0];
      end
      if (neg) begin
         o = 32'(33'd0 - m);
      end else if (m > 33'h0_7FFF_FFFF) begin
         o = 32'h7FFF_FFFF;
      end else begin
         o = m[31:0];
      end
      return o;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !(done_ff && !out_free);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Rounded products: first-order rotation terms and position increments.
   assign prod_r28 = prod + 66'sh1000_0000;
   assign prod_r29 = prod + 66'sh2000_0000;
   assign dterm    = prod_r28[65:29];
   assign inc      = prod_r29[65:30];

   assign head_sum  = {{2{heading_ff[31]}}, heading_ff} + {{2{dt_ff[31]}}, dt_ff};
   assign head_wrap = opi_pkg::wrap_angle(head_sum);

   assign slot0    = (pc_ff == '0);
   assign slot_hit = ({{(17 - PC_W){1'b0}}, pc_ff} == {10'd0, slot_ff});

   assign mag_x = xt_ff[47] ? (48'd0 - xt_ff) : xt_ff;
   assign mag_y = yt_ff[47] ? (48'd0 - yt_ff) : yt_ff;
   assign msum  = {1'b0, prod[56:0]} + {25'd0, plr_ff};

   assign cord_start = (state_ff == S_SETH) || ((state_ff == S_ROT) && (slot0 || slot_hit));
   assign cord_head  = (state_ff == S_ROT) ? head_wrap : heading_ff;
   assign div_start  = (state_ff == S_DXGO) || (state_ff == S_DYGO);
   assign div_meters = (state_ff == S_DYGO) ? sy_ff : sx_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         S_DCOS: begin
            mul_a = {sin_ff[31], sin_ff};
            mul_b = {dt_ff[31], dt_ff};
         end
         S_DSIN: begin
            mul_a = {cos_ff[31], cos_ff};
            mul_b = {dt_ff[31], dt_ff};
         end
         S_MULX: begin
            mul_a = {dv_ff[31], dv_ff};
            mul_b = {cos_ff[31], cos_ff};
         end
         S_MULY: begin
            mul_a = {dv_ff[31], dv_ff};
            mul_b = {sin_ff[31], sin_ff};
         end
         S_MXLO: begin
            mul_a = {9'd0, mag_x[23:0]};
            mul_b = {1'b0, mpt_ff};
         end
         S_MXHI: begin
            mul_a = {9'd0, mag_x[47:24]};
            mul_b = {1'b0, mpt_ff};
         end
         S_MYLO: begin
            mul_a = {9'd0, mag_y[23:0]};
            mul_b = {1'b0, mpt_ff};
         end
         S_MYHI: begin
            mul_a = {9'd0, mag_y[47:24]};
            mul_b = {1'b0, mpt_ff};
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   // Sequencer and datapath updates.
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      heading_in   = heading_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;
      xt_in        = xt_ff;
      yt_in        = yt_ff;
      pc_in        = pc_ff;
      mpt_in       = mpt_ff;
      slot_in      = slot_ff;
      dt_in        = dt_ff;
      dv_in        = dv_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      set_in       = set_ff;
      dcos_in      = dcos_ff;
      rc_in        = rc_ff;
      rs_in        = rs_ff;
      plr_in       = plr_ff;
      xm_in        = xm_ff;
      ym_in        = ym_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // Register writes are to arrive only while idle; the block itself does not enforce this.
      if (csr_we) begin
         case (csr_index)
            opi_pkg::CSR_MPT:  mpt_in  = csr_wdata;
            opi_pkg::CSR_SLOT: slot_in = csr_wdata[6:0];
            default:           mpt_in  = mpt_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            // Hand a finished pose to the output register.
            if (done_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {heading_ff, ym_ff, xm_ff};
               done_in      = 1'b0;
            end
            if (req_tvalid && !(done_ff && !out_free)) begin
               dt_in  = req_tdata[31:0];
               dv_in  = req_tdata[63:32];
               sx_in  = req_tdata[95:64];
               sy_in  = req_tdata[127:96];
               set_in = req_tuser;
               if (req_tuser) begin
                  heading_in = opi_pkg::wrap_angle({{2{req_tdata[159]}}, req_tdata[159:128]});
                  state_in   = S_SETH;
               end else begin
                  state_in = S_DCOS;
               end
            end
         end
         S_DCOS: begin
            state_in = S_DSIN;
         end
         S_DSIN: begin
            dcos_in  = dterm;
            state_in = S_ROT;
         end
         S_ROT: begin
            // First-order rotation; an exact refresh replaces one term later.
            heading_in = head_wrap;
            cos_in     = opi_pkg::sat32({{8{cos_ff[31]}}, cos_ff} - {{3{dcos_ff[36]}}, dcos_ff});
            sin_in     = opi_pkg::sat32({{8{sin_ff[31]}}, sin_ff} + {{3{dterm[36]}}, dterm});
            rc_in      = slot0;
            rs_in      = !slot0 && slot_hit;
            if (pc_ff == PC_W'(opi_pkg::REFRESH_PERIOD - 1)) begin
               pc_in = '0;
            end else begin
               pc_in = pc_ff + PC_W'(1);
            end
            state_in = (slot0 || slot_hit) ? S_CORD : S_MULX;
         end
         S_SETH: begin
            rc_in    = 1'b1;
            rs_in    = 1'b1;
            state_in = S_CORD;
         end
         S_CORD: begin
            if (cord_res.done) begin
               if (rc_ff) begin
                  cos_in = cord_res.cos;
               end
               if (rs_ff) begin
                  sin_in = cord_res.sin;
               end
               state_in = set_ff ? S_DXGO : S_MULX;
            end
         end
         S_MULX: begin
            state_in = S_MULY;
         end
         S_MULY: begin
            xt_in    = sat48({{2{xt_ff[47]}}, xt_ff} + {{14{inc[35]}}, inc});
            state_in = S_ADDY;
         end
         S_ADDY: begin
            yt_in    = sat48({{2{yt_ff[47]}}, yt_ff} + {{14{inc[35]}}, inc});
            state_in = S_MXLO;
         end
         S_DXGO: begin
            state_in = S_DXW;
         end
         S_DXW: begin
            if (div_res.done) begin
               xt_in    = div_res.ticks;
               state_in = S_DYGO;
            end
         end
         S_DYGO: begin
            state_in = S_DYW;
         end
         S_DYW: begin
            if (div_res.done) begin
               yt_in    = div_res.ticks;
               state_in = S_MXLO;
            end
         end
         S_MXLO: begin
            state_in = S_MXHI;
         end
         S_MXHI: begin
            plr_in   = 33'(({1'b0, prod[56:0]} + 58'h80_0000) >> 24);
            state_in = S_MXFIN;
         end
         S_MXFIN: begin
            xm_in    = to_meters(msum, xt_ff[47]);
            state_in = S_MYLO;
         end
         S_MYLO: begin
            state_in = S_MYHI;
         end
         S_MYHI: begin
            plr_in   = 33'(({1'b0, prod[56:0]} + 58'h80_0000) >> 24);
            state_in = S_MYFIN;
         end
         S_MYFIN: begin
            ym_in    = to_meters(msum, yt_ff[47]);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   opi_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   opi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .heading (cord_head),
      .res     (cord_res)
   );

   opi_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .meters (div_meters),
      .scale  (mpt_ff),
      .res    (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         heading_ff   <= 32'sd0;
         cos_ff       <= opi_pkg::COS_RESET;
         sin_ff       <= 32'sd0;
         xt_ff        <= 48'sd0;
         yt_ff        <= 48'sd0;
         pc_ff        <= '0;
         mpt_ff       <= opi_pkg::MPT_RESET;
         slot_ff      <= opi_pkg::SLOT_RESET;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         heading_ff   <= heading_in;
         cos_ff       <= cos_in;
         sin_ff       <= sin_in;
         xt_ff        <= xt_in;
         yt_ff        <= yt_in;
         pc_ff        <= pc_in;
         mpt_ff       <= mpt_in;
         slot_ff      <= slot_in;
      end
      dt_ff       <= dt_in;
      dv_ff       <= dv_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      set_ff      <= set_in;
      dcos_ff     <= dcos_in;
      rc_ff       <= rc_in;
      rs_ff       <= rs_in;
      plr_ff      <= plr_in;
      xm_ff       <= xm_in;
      ym_ff       <= ym_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/opi_checker.sv =====
// Port-level assertions for the odometry pose integrator, bound to the top level.
module opi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata
);

   // A pending result stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // The block is busy in the cycle after it takes an item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while the previous one is still in work");

   // The reported heading always lies within (-pi, pi].
   a_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[95:64]) <= $signed(opi_pkg::PI_Q[31:0]))
                  && ($signed(rsp_tdata[95:64]) > -$signed(opi_pkg::PI_Q[31:0])))
      else $error("heading out of range");

   // A waiting result keeps its data until it is taken.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while waiting");

endmodule

bind odometry_pose_integrator opi_checker u_opi_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the odometry pose integrator.
`timescale 1ns / 1ps

module tb;

   localparam int     HALF_PERIOD = 6;
   localparam int     CYCLE_LIMIT = 3000000;
   localparam int     DRAIN_WAIT  = 300;
   localparam longint PI_L        = 64'sd1686629713;
   localparam longint HALF_PI_L   = 64'sd843314856;
   localparam longint TICK_MAX    = 64'sd140737488355327;
   localparam longint TICK_MIN    = -64'sd140737488355328;
   localparam longint I32_MAX     = 64'sd2147483647;
   localparam longint I32_MIN     = -64'sd2147483648;
   localparam bit     KIND_INTEGRATE = 1'b0;
   localparam bit     KIND_SET       = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] turn_step;
      logic signed [31:0] distance_step;
      logic signed [31:0] set_x_m;
      logic signed [31:0] set_y_m;
      logic signed [31:0] set_heading;
   } odo_item_t;

   typedef struct packed {
      logic signed [31:0] x_m;
      logic signed [31:0] y_m;
      logic signed [31:0] heading_out;
   } pose_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_wdata = '0;

   odometry_pose_integrator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Pending stimulus, expected poses and run control.
   odo_item_t pending_items[$];
   pose_t     expected_poses[$];
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;
   int        hold_off_cycles = 0;
   int        cycle_count = 0;
   int        error_count = 0;
   bit        req_fire = 1'b0;

   // Shadow state of the integrator.
   longint unsigned mpt_shadow;
   int unsigned     slot_shadow;
   longint          heading_s, cos_s, sin_s, xt_s, yt_s;
   int unsigned     period_s;

   function automatic longint sat_range(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint wrap_pi(input longint a);
      if (a > PI_L) return a - 2 * PI_L;
      if (a <= -PI_L) return a + 2 * PI_L;
      return a;
   endfunction

   function automatic longint atan_entry(input int i);
      case (i)
         0: return 843314857;
         1: return 497837829;
         2: return 263043837;
         3: return 133525159;
         4: return 67021687;
         5: return 33543516;
         6: return 16775851;
         7: return 8388437;
         8: return 4194283;
         9: return 2097149;
         31: return 0;
         default: return 64'sd1 <<< (30 - i);
      endcase
   endfunction

   // Rotation-mode CORDIC on a heading folded into the right half plane.
   task automatic rotate_exact(input longint h, output longint c, output longint s);
      bit     flip;
      longint vx, vy, z, dx, dy;
      flip = 1'b0;
      vx = 652032874;
      vy = 0;
      if (h > HALF_PI_L) begin
         h = h - PI_L;
         flip = 1'b1;
      end else if (h < -HALF_PI_L) begin
         h = h + PI_L;
         flip = 1'b1;
      end
      z = h * 2;
      for (int i = 0; i < opi_pkg::CORDIC_STEPS && i < 32; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (z >= 0) begin
            vx = vx - dx; vy = vy + dy; z = z - atan_entry(i);
         end else begin
            vx = vx + dx; vy = vy - dy; z = z + atan_entry(i);
         end
      end
      if (flip) begin
         vx = -vx;
         vy = -vy;
      end
      c = sat_range(vx, I32_MIN, I32_MAX);
      s = sat_range(vy, I32_MIN, I32_MAX);
   endtask

   function automatic logic [31:0] ticks_to_m(input longint t);
      longint unsigned mag, a, b, r;
      mag = (t < 0) ? longint'(-t) : longint'(t);
      a = mag * (mpt_shadow >> 16);
      b = mag * (mpt_shadow & 64'hFFFF) + (64'd1 << 23);
      r = (a + (b >> 16)) >> 8;
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      if (t < 0) return 32'(-longint'(r));
      return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(r);
   endfunction

   function automatic longint m_to_ticks(input longint m);
      longint unsigned d, mag, r;
      d = (mpt_shadow != 0) ? mpt_shadow : 64'd1;
      mag = ((m < 0) ? longint'(-m) : longint'(m)) << 24;
      r = (mag + d / 2) / d;
      if (r > longint'(TICK_MAX)) r = TICK_MAX;
      return (m < 0) ? -longint'(r) : longint'(r);
   endfunction

   // Advance the shadow pose by one item and return the expected pose.
   task automatic advance_pose(input odo_item_t it, output pose_t p);
      longint dt, dv, dcos, dsin, ec, es;
      int unsigned slot;
      if (it.kind == KIND_SET) begin
         heading_s = wrap_pi(longint'(it.set_heading));
         rotate_exact(heading_s, cos_s, sin_s);
         xt_s = m_to_ticks(longint'(it.set_x_m));
         yt_s = m_to_ticks(longint'(it.set_y_m));
      end else begin
         dt = longint'(it.turn_step);
         dv = longint'(it.distance_step);
         dcos = (sin_s * dt + (64'sd1 << 28)) >>> 29;
         dsin = (cos_s * dt + (64'sd1 << 28)) >>> 29;
         slot = period_s;
         heading_s = wrap_pi(heading_s + dt);
         period_s = (period_s + 1) % opi_pkg::REFRESH_PERIOD;
         if (slot == 0) begin
            // Cosine refresh slot; it wins over a sine slot of zero.
            sin_s = sat_range(sin_s + dsin, I32_MIN, I32_MAX);
            rotate_exact(heading_s, ec, es);
            cos_s = ec;
         end else if (slot == slot_shadow) begin
            cos_s = sat_range(cos_s - dcos, I32_MIN, I32_MAX);
            rotate_exact(heading_s, ec, es);
            sin_s = es;
         end else begin
            ec = sat_range(cos_s - dcos, I32_MIN, I32_MAX);
            sin_s = sat_range(sin_s + dsin, I32_MIN, I32_MAX);
            cos_s = ec;
         end
         xt_s = sat_range(xt_s + ((dv * cos_s + (64'sd1 << 29)) >>> 30), TICK_MIN, TICK_MAX);
         yt_s = sat_range(yt_s + ((dv * sin_s + (64'sd1 << 29)) >>> 30), TICK_MIN, TICK_MAX);
      end
      p.x_m = ticks_to_m(xt_s);
      p.y_m = ticks_to_m(yt_s);
      p.heading_out = heading_s[31:0];
   endtask

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Input side monitor: every accepted item updates the prediction.
   always @(posedge clock) begin
      pose_t p;
      req_fire <= 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         advance_pose({req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                       req_tdata[127:96], req_tdata[159:128]} , p);
         expected_poses.push_back(p);
         req_fire <= 1'b1;
      end
   end

   // Output side monitor: compare each accepted pose with the oldest expectation.
   always @(posedge clock) begin
      pose_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_poses.size() == 0) begin
            $error("unexpected pose %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_poses.pop_front();
            if (rsp_tdata[31:0] !== e.x_m) begin
               $error("x_m expected %h actual %h", e.x_m, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== e.y_m) begin
               $error("y_m expected %h actual %h", e.y_m, rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tdata[95:64] !== e.heading_out) begin
               $error("heading_out expected %h actual %h", e.heading_out, rsp_tdata[95:64]);
               error_count++;
            end
         end
      end
   end

   // Item driver: holds an offered item until it is taken.
   always @(negedge clock) begin
      odo_item_t it;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= it.kind;
            req_tdata  <= {it.set_heading, it.set_y_m, it.set_x_m, it.distance_step,
                           it.turn_step};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver readiness, with an optional long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic odo_item_t make_item(input bit kind, input longint turn, input longint travel,
                                           input longint sx, input longint sy, input longint sh);
      odo_item_t it;
      it.kind = kind;
      it.turn_step = turn[31:0];
      it.distance_step = travel[31:0];
      it.set_x_m = sx[31:0];
      it.set_y_m = sy[31:0];
      it.set_heading = sh[31:0];
      return it;
   endfunction

   function automatic longint rand_angle();
      return longint'($urandom_range(32'd3373259426, 0)) - PI_L;
   endfunction

   // Random item: mostly integrate with modest turns, some sets and wide turns.
   function automatic odo_item_t rand_item();
      longint turn;
      int     pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         return make_item(KIND_SET, rand_angle(), longint'($signed($urandom)),
                          (pick < 4) ? longint'($signed($urandom))
                                     : longint'($signed($urandom)) >>> 8,
                          longint'($signed($urandom)) >>> ($urandom_range(8)),
                          rand_angle());
      end
      turn = (pick < 20) ? rand_angle() : longint'($signed($urandom)) >>> $urandom_range(20, 8);
      return make_item(KIND_INTEGRATE, turn,
                       longint'($signed($urandom)) >>> $urandom_range(12),
                       longint'($signed($urandom)), longint'($signed($urandom)), rand_angle());
   endfunction

   task automatic write_csr(input logic idx, input logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == opi_pkg::CSR_MPT) mpt_shadow = val;
      else slot_shadow = val[6:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Let the block drain before touching the registers.
   task automatic drain_all();
      while (pending_items.size() != 0 || req_tvalid || expected_poses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_poses.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_items.push_back(rand_item());
   endtask

   initial begin
      mpt_shadow = opi_pkg::MPT_RESET;
      slot_shadow = opi_pkg::SLOT_RESET;
      heading_s = 0;
      cos_s = 64'sd1 << 30;
      sin_s = 0;
      xt_s = 0;
      yt_s = 0;
      period_s = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(negedge clock);

      // Directed part: heading extremes and wrap, position extremes, distance extremes.
      pending_items.push_back(make_item(KIND_INTEGRATE, PI_L, 64'sh7FFFFFFF, 0, 0, 0));
      pending_items.push_back(make_item(KIND_INTEGRATE, PI_L, -64'sh80000000, 0, 0, 0));
      pending_items.push_back(make_item(KIND_INTEGRATE, -PI_L, 64'sh10000, 0, 0, 0));
      pending_items.push_back(make_item(KIND_SET, 0, 0, I32_MAX, I32_MIN, PI_L));
      pending_items.push_back(make_item(KIND_INTEGRATE, -PI_L, 64'sh7FFFFFFF, 0, 0, 0));
      pending_items.push_back(make_item(KIND_SET, 0, 0, I32_MIN, I32_MAX, -PI_L));
      pending_items.push_back(make_item(KIND_SET, 0, 0, 0, 0, HALF_PI_L + 1));
      pending_items.push_back(make_item(KIND_SET, 0, 0, -1, 1, -HALF_PI_L - 1));
      pending_items.push_back(make_item(KIND_SET, -1, -1, 64'sh01000000, 0, 0));
      pending_items.push_back(make_item(KIND_INTEGRATE, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(KIND_INTEGRATE, 1, -1, -1, -1, -1));
      pending_items.push_back(make_item(KIND_INTEGRATE, -1, 64'sh7FFFFFFF, 0, 0, 0));
      queue_random(180);
      drain_all();

      // Smallest scale and earliest sine slot, sender idling.
      write_csr(opi_pkg::CSR_MPT, 32'd1);
      write_csr(opi_pkg::CSR_SLOT, 32'd1);
      send_idle_pct = 47;
      pending_items.push_back(make_item(KIND_SET, 0, 0, I32_MAX, I32_MIN, 0));
      pending_items.push_back(make_item(KIND_INTEGRATE, 64'sd1000000, 64'sh7FFFFFFF, 0, 0, 0));
      queue_random(180);
      drain_all();

      // Largest scale and last sine slot, receiver stalling after a long hold-off.
      write_csr(opi_pkg::CSR_MPT, 32'hFFFF_FFFF);
      write_csr(opi_pkg::CSR_SLOT, 32'd127);
      send_idle_pct = 0;
      recv_idle_pct = 47;
      hold_off_cycles = 3000;
      queue_random(180);
      drain_all();

      // Zero scale and a sine slot of zero, both sides idling.
      write_csr(opi_pkg::CSR_MPT, 32'd0);
      write_csr(opi_pkg::CSR_SLOT, 32'd0);
      send_idle_pct = 10;
      recv_idle_pct = 10;
      pending_items.push_back(make_item(KIND_SET, 0, 0, 64'sh12345678, -64'sh1234567, PI_L));
      queue_random(90);
      drain_all();

      // Random scale and slot.
      write_csr(opi_pkg::CSR_MPT, $urandom);
      write_csr(opi_pkg::CSR_SLOT, $urandom_range(127, 1));
      queue_random(110);
      drain_all();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/opi_pkg.sv
rtl/opi_mul.sv
rtl/opi_cordic.sv
rtl/opi_div.sv
rtl/odometry_pose_integrator.sv
rtl/opi_checker.sv
tb/tb.sv
